>>> rtl/core/pixel_histogram_min_max_sum_unit_defines.svh
// Assertion macros used by the checker of the histogram unit.
`ifndef PIXEL_HISTOGRAM_MIN_MAX_SUM_UNIT_DEFINES_SVH
`define PIXEL_HISTOGRAM_MIN_MAX_SUM_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PHMMS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define PHMMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/phmms_pkg.sv
package phmms_pkg;

   localparam int BIN_COUNT   = 8192;
   localparam int PIXEL_BITS  = 13;
   localparam int BIN_ADDR_W  = $clog2(BIN_COUNT);
   localparam int COUNT_W     = 32;
   localparam int MIN_W       = PIXEL_BITS + 1;
   localparam int SUM_W       = 46;
   localparam int OUT_SUM_W   = 45;
   localparam int DIM_W       = 16;
   localparam int TARGET_W    = 2 * DIM_W;
   localparam int OPCODE_W    = 2;
   localparam int CSR_INDEX_W = 1;

   localparam logic [MIN_W-1:0] MIN_IDLE = {1'b1, {PIXEL_BITS{1'b0}}};

   typedef enum logic [OPCODE_W-1:0] {
      OP_PIXEL     = 2'd0,
      OP_READ_BIN  = 2'd1,
      OP_CLEAR_BIN = 2'd2
   } opcode_type;

   localparam logic RESULT_FRAME = 1'b0;
   localparam logic RESULT_BIN   = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

endpackage

>>> rtl/core/pixel_histogram_min_max_sum_unit.sv
// Frame histogram with min, max and sum. After reset the unit sweeps the 8192-entry bin
// memory to zero, one bin per clock, and holds req_ready low until the sweep ends;
// configuration writes are taken throughout. It then accepts one item per clock unless
// a stalled result holds it: each item reads its bin from the single memory in the cycle
// it is accepted, and stage s1 writes back the modified bin of a pixel or clear item,
// with the last write forwarded so that back-to-back hits on one bin count correctly.
// A bin read or a completed frame goes from stage s1 into the rsp_ registers. A frame
// completes when the pixel count reaches frame_width * frame_height; a zero product never completes one.
module pixel_histogram_min_max_sum_unit
   import phmms_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [OPCODE_W-1:0]    req_opcode,
   input  logic [PIXEL_BITS-1:0]  req_pixel_value,
   input  logic [BIN_ADDR_W-1:0]  req_bin_index,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_result_kind,
   output logic [COUNT_W-1:0]     rsp_bin_count,
   output logic [MIN_W-1:0]       rsp_min_value,
   output logic [PIXEL_BITS-1:0]  rsp_max_value,
   output logic [OUT_SUM_W-1:0]   rsp_pixel_sum
);

   logic [COUNT_W-1:0]    bin_store_ff [BIN_COUNT];
   logic [COUNT_W-1:0]    mem_rdata_ff;

   state_type             state_ff, state_in;
   logic [BIN_ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   logic [DIM_W-1:0]      frame_width_ff, frame_width_in;
   logic [DIM_W-1:0]      frame_height_ff, frame_height_in;
   logic [TARGET_W-1:0]   target_ff, target_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic [OPCODE_W-1:0]   s1_op_ff, s1_op_in;
   logic [BIN_ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic [PIXEL_BITS-1:0] s1_pix_ff, s1_pix_in;

   logic                  fwd_valid_ff, fwd_valid_in;
   logic [BIN_ADDR_W-1:0] fwd_addr_ff, fwd_addr_in;
   logic [COUNT_W-1:0]    fwd_data_ff, fwd_data_in;

   logic [MIN_W-1:0]      run_min_ff, run_min_in;
   logic [PIXEL_BITS-1:0] run_max_ff, run_max_in;
   logic [SUM_W-1:0]      run_sum_ff, run_sum_in;
   logic [TARGET_W-1:0]   pix_count_ff, pix_count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [MIN_W-1:0]      rsp_min_ff, rsp_min_in;
   logic [PIXEL_BITS-1:0] rsp_max_ff, rsp_max_in;
   logic [OUT_SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;

   logic                  req_fire;
   logic [BIN_ADDR_W-1:0] rd_addr;
   logic [COUNT_W-1:0]    cur_count;
   logic                  s1_pixel;
   logic                  s1_read;
   logic                  s1_clear;
   logic [TARGET_W-1:0]   count_plus;
   logic                  frame_done;
   logic                  s1_result;
   logic                  advance;
   logic [MIN_W-1:0]      min_upd;
   logic [PIXEL_BITS-1:0] max_upd;
   logic [SUM_W-1:0]      sum_upd;
   logic                  mem_we;
   logic [BIN_ADDR_W-1:0] mem_waddr;
   logic [COUNT_W-1:0]    mem_wdata;
   logic                  s1_we;

   assign csr_ready = 1'b1;

   assign rd_addr = (req_opcode == OP_PIXEL) ? BIN_ADDR_W'(req_pixel_value) : req_bin_index;

   assign cur_count = (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) ? fwd_data_ff : mem_rdata_ff;
   assign s1_pixel  = s1_valid_ff && s1_op_ff == OP_PIXEL;
   assign s1_read   = s1_valid_ff && s1_op_ff == OP_READ_BIN;
   assign s1_clear  = s1_valid_ff && s1_op_ff == OP_CLEAR_BIN;

   assign count_plus = pix_count_ff + TARGET_W'(1);
   assign frame_done = s1_pixel && target_ff != '0 && count_plus >= target_ff;
   assign s1_result  = s1_read || frame_done;

   assign advance   = !(s1_result && rsp_valid_ff && !rsp_ready);
   assign req_ready = advance && state_ff == ST_RUN;
   assign req_fire  = req_valid && req_ready;

   assign min_upd = (MIN_W'(s1_pix_ff) < run_min_ff) ? MIN_W'(s1_pix_ff) : run_min_ff;
   assign max_upd = (s1_pix_ff > run_max_ff) ? s1_pix_ff : run_max_ff;
   assign sum_upd = run_sum_ff + SUM_W'(s1_pix_ff);

   assign s1_we = advance && (s1_pixel || s1_clear);

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = s1_we;
         mem_waddr = s1_addr_ff;
         mem_wdata = s1_pixel ? cur_count + COUNT_W'(1) : '0;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + BIN_ADDR_W'(1);
            if (clr_addr_ff == BIN_ADDR_W'(BIN_COUNT - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: begin
            end
         endcase
      end
      target_in = TARGET_W'(frame_width_ff) * TARGET_W'(frame_height_ff);
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_op_in     = s1_op_ff;
      s1_addr_in   = s1_addr_ff;
      s1_pix_in    = s1_pix_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_data_in  = fwd_data_ff;
      if (state_ff == ST_CLEAR) begin
         s1_valid_in  = 1'b0;
         fwd_valid_in = 1'b0;
      end else if (advance) begin
         s1_valid_in  = req_fire;
         s1_op_in     = req_opcode;
         s1_addr_in   = rd_addr;
         s1_pix_in    = req_pixel_value;
         fwd_valid_in = s1_we;
         fwd_addr_in  = mem_waddr;
         fwd_data_in  = mem_wdata;
      end
   end

   always_comb begin
      run_min_in   = run_min_ff;
      run_max_in   = run_max_ff;
      run_sum_in   = run_sum_ff;
      pix_count_in = pix_count_ff;
      if (s1_pixel && advance) begin
         if (frame_done) begin
            run_min_in   = MIN_IDLE;
            run_max_in   = '0;
            run_sum_in   = '0;
            pix_count_in = '0;
         end else begin
            run_min_in   = min_upd;
            run_max_in   = max_upd;
            run_sum_in   = sum_upd;
            pix_count_in = count_plus;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_count_in = rsp_count_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_sum_in   = rsp_sum_ff;
      if (s1_result && advance) begin
         rsp_valid_in = 1'b1;
         if (s1_read) begin
            rsp_kind_in  = RESULT_BIN;
            rsp_count_in = cur_count;
            rsp_min_in   = '0;
            rsp_max_in   = '0;
            rsp_sum_in   = '0;
         end else begin
            rsp_kind_in  = RESULT_FRAME;
            rsp_count_in = '0;
            rsp_min_in   = min_upd;
            rsp_max_in   = max_upd;
            rsp_sum_in   = sum_upd[OUT_SUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_store_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mem_rdata_ff <= bin_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
         target_ff       <= '0;
         s1_valid_ff     <= 1'b0;
         fwd_valid_ff    <= 1'b0;
         run_min_ff      <= MIN_IDLE;
         run_max_ff      <= '0;
         run_sum_ff      <= '0;
         pix_count_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         target_ff       <= target_in;
         s1_valid_ff     <= s1_valid_in;
         fwd_valid_ff    <= fwd_valid_in;
         run_min_ff      <= run_min_in;
         run_max_ff      <= run_max_in;
         run_sum_ff      <= run_sum_in;
         pix_count_ff    <= pix_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff     <= s1_op_in;
      s1_addr_ff   <= s1_addr_in;
      s1_pix_ff    <= s1_pix_in;
      fwd_addr_ff  <= fwd_addr_in;
      fwd_data_ff  <= fwd_data_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_count_ff <= rsp_count_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_sum_ff   <= rsp_sum_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_bin_count   = rsp_count_ff;
   assign rsp_min_value   = rsp_min_ff;
   assign rsp_max_value   = rsp_max_ff;
   assign rsp_pixel_sum   = rsp_sum_ff;

endmodule

>>> rtl/core/phmms_checker.sv
`include "pixel_histogram_min_max_sum_unit_defines.svh"

module phmms_checker
   import phmms_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_result_kind,
   input logic [COUNT_W-1:0]     rsp_bin_count,
   input logic [MIN_W-1:0]       rsp_min_value,
   input logic [PIXEL_BITS-1:0]  rsp_max_value,
   input logic [OUT_SUM_W-1:0]   rsp_pixel_sum
);

   // hold a stalled result
   `PHMMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_kind) && $stable(rsp_bin_count) && $stable(rsp_min_value) && $stable(rsp_max_value) && $stable(rsp_pixel_sum), "stalled result changed")

   `PHMMS_ASSERT_NOW(a_bin_zero_stats, rsp_valid && rsp_result_kind == RESULT_BIN, rsp_min_value == '0 && rsp_max_value == '0 && rsp_pixel_sum == '0, "bin answer carries frame statistics")

   `PHMMS_ASSERT_NOW(a_frame_order, rsp_valid && rsp_result_kind == RESULT_FRAME, rsp_bin_count == '0 && rsp_min_value != MIN_IDLE && rsp_min_value <= {1'b0, rsp_max_value}, "frame result inconsistent")

   `PHMMS_ASSERT_NOW(a_clear_blocks, $past(reset), !req_ready, "input taken during bin clearing")

   `PHMMS_ASSERT_NOW(a_rsp_cause, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without a transfer two cycles before")

endmodule

bind pixel_histogram_min_max_sum_unit phmms_checker u_phmms_checker (.*);
